>>> hw/rtl/mtd_pkg.sv
`default_nettype none

package mtd_pkg;

    // longest dot/dash pattern a token may hold
    localparam int MAX_SYMBOLS = 7;
    localparam int SYM_W       = MAX_SYMBOLS;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [7:0]       t_char;

    // text bytes with a meaning of their own
    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_DASH  = 8'h2D;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_SPACE = 8'h20;

    // one request as seen by the token tracker
    typedef struct packed {
        logic  req;
        logic  eot;
        t_char text;
    } t_tok_in;

    // decode result of one request
    typedef struct packed {
        logic  valid;
        t_char data;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/mtd_token.sv
`default_nettype none

module mtd_token
    import mtd_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_tok_in i_in,
    output t_res    o_res
);

    localparam t_char WS_LO    = 8'h09;
    localparam t_char WS_HI    = 8'h0D;

    t_sym r_bits,    n_bits;
    t_cnt r_count,   n_count;
    logic r_open,    n_open;
    logic r_invalid, n_invalid;
    logic r_slash,   n_slash;

    logic is_space;
    logic is_close;
    t_res table_hit;

    function automatic t_res lookup(input t_cnt cnt, input t_sym bits);
        t_res r;
        r.valid = 1'b1;
        r.data  = 8'h00;
        case ({cnt, bits})
            {CNT_W'(2), SYM_W'(7'b0000001)}: r.data = "A";
            {CNT_W'(4), SYM_W'(7'b0001000)}: r.data = "B";
            {CNT_W'(4), SYM_W'(7'b0001010)}: r.data = "C";
            {CNT_W'(3), SYM_W'(7'b0000100)}: r.data = "D";
            {CNT_W'(1), SYM_W'(7'b0000000)}: r.data = "E";
            {CNT_W'(4), SYM_W'(7'b0000010)}: r.data = "F";
            {CNT_W'(3), SYM_W'(7'b0000110)}: r.data = "G";
            {CNT_W'(4), SYM_W'(7'b0000000)}: r.data = "H";
            {CNT_W'(2), SYM_W'(7'b0000000)}: r.data = "I";
            {CNT_W'(4), SYM_W'(7'b0000111)}: r.data = "J";
            {CNT_W'(3), SYM_W'(7'b0000101)}: r.data = "K";
            {CNT_W'(4), SYM_W'(7'b0000100)}: r.data = "L";
            {CNT_W'(2), SYM_W'(7'b0000011)}: r.data = "M";
            {CNT_W'(2), SYM_W'(7'b0000010)}: r.data = "N";
            {CNT_W'(3), SYM_W'(7'b0000111)}: r.data = "O";
            {CNT_W'(4), SYM_W'(7'b0000110)}: r.data = "P";
            {CNT_W'(4), SYM_W'(7'b0001101)}: r.data = "Q";
            {CNT_W'(3), SYM_W'(7'b0000010)}: r.data = "R";
            {CNT_W'(3), SYM_W'(7'b0000000)}: r.data = "S";
            {CNT_W'(1), SYM_W'(7'b0000001)}: r.data = "T";
            {CNT_W'(3), SYM_W'(7'b0000001)}: r.data = "U";
            {CNT_W'(4), SYM_W'(7'b0000001)}: r.data = "V";
            {CNT_W'(3), SYM_W'(7'b0000011)}: r.data = "W";
            {CNT_W'(4), SYM_W'(7'b0001001)}: r.data = "X";
            {CNT_W'(4), SYM_W'(7'b0001011)}: r.data = "Y";
            {CNT_W'(4), SYM_W'(7'b0001100)}: r.data = "Z";
            {CNT_W'(5), SYM_W'(7'b0011111)}: r.data = "0";
            {CNT_W'(5), SYM_W'(7'b0001111)}: r.data = "1";
            {CNT_W'(5), SYM_W'(7'b0000111)}: r.data = "2";
            {CNT_W'(5), SYM_W'(7'b0000011)}: r.data = "3";
            {CNT_W'(5), SYM_W'(7'b0000001)}: r.data = "4";
            {CNT_W'(5), SYM_W'(7'b0000000)}: r.data = "5";
            {CNT_W'(5), SYM_W'(7'b0010000)}: r.data = "6";
            {CNT_W'(5), SYM_W'(7'b0011000)}: r.data = "7";
            {CNT_W'(5), SYM_W'(7'b0011100)}: r.data = "8";
            {CNT_W'(5), SYM_W'(7'b0011110)}: r.data = "9";
            {CNT_W'(6), SYM_W'(7'b0010101)}: r.data = ".";
            {CNT_W'(6), SYM_W'(7'b0110011)}: r.data = ",";
            {CNT_W'(6), SYM_W'(7'b0001100)}: r.data = "?";
            {CNT_W'(6), SYM_W'(7'b0011110)}: r.data = "'";
            {CNT_W'(6), SYM_W'(7'b0101011)}: r.data = "!";
            {CNT_W'(5), SYM_W'(7'b0010010)}: r.data = "/";
            {CNT_W'(5), SYM_W'(7'b0010110)}: r.data = "(";
            {CNT_W'(6), SYM_W'(7'b0101101)}: r.data = ")";
            {CNT_W'(5), SYM_W'(7'b0001000)}: r.data = "&";
            {CNT_W'(6), SYM_W'(7'b0111000)}: r.data = ":";
            {CNT_W'(6), SYM_W'(7'b0101010)}: r.data = ";";
            {CNT_W'(5), SYM_W'(7'b0010001)}: r.data = "=";
            {CNT_W'(5), SYM_W'(7'b0001010)}: r.data = "+";
            {CNT_W'(6), SYM_W'(7'b0100001)}: r.data = "-";
            {CNT_W'(6), SYM_W'(7'b0001101)}: r.data = "_";
            {CNT_W'(6), SYM_W'(7'b0010010)}: r.data = "\"";
            {CNT_W'(7), SYM_W'(7'b0001001)}: r.data = "$";
            {CNT_W'(6), SYM_W'(7'b0011010)}: r.data = "@";
            default: r.valid = 1'b0;
        endcase
        return r;
    endfunction

    assign is_space  = (i_in.text == CH_SPACE) || (i_in.text inside {[WS_LO:WS_HI]});
    assign is_close  = i_in.eot || is_space;
    assign table_hit = lookup(r_count, r_bits);

    // result of closing the current token
    always_comb begin
        o_res.valid = 1'b0;
        o_res.data  = table_hit.data;
        if (i_in.req && is_close && r_open && !r_invalid) begin
            if (r_slash) begin
                o_res.valid = 1'b1;
                o_res.data  = CH_SPACE;
            end else begin
                o_res.valid = table_hit.valid;
            end
        end
    end

    always_comb begin
        n_bits    = r_bits;
        n_count   = r_count;
        n_open    = r_open;
        n_invalid = r_invalid;
        n_slash   = r_slash;
        if (i_in.req) begin
            if (is_close) begin
                n_bits    = '0;
                n_count   = '0;
                n_open    = 1'b0;
                n_invalid = 1'b0;
                n_slash   = 1'b0;
            end else begin
                n_open = 1'b1;
                if (i_in.text == CH_DOT || i_in.text == CH_DASH) begin
                    if (r_slash || r_count >= CNT_W'(MAX_SYMBOLS)) begin
                        n_invalid = 1'b1;
                    end else if (!r_invalid) begin
                        n_bits  = {r_bits[SYM_W-2:0], i_in.text == CH_DASH};
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (i_in.text == CH_SLASH) begin
                    if (r_count == '0 && !r_slash && !r_invalid) begin
                        n_slash = 1'b1;
                    end else begin
                        n_invalid = 1'b1;
                    end
                end else begin
                    n_invalid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= '0;
            r_count   <= '0;
            r_open    <= 1'b0;
            r_invalid <= 1'b0;
            r_slash   <= 1'b0;
        end else begin
            r_bits    <= n_bits;
            r_count   <= n_count;
            r_open    <= n_open;
            r_invalid <= n_invalid;
            r_slash   <= n_slash;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/morse_text_decoder_core.sv
`default_nettype none

// Morse text decoder. Bytes of Morse text ('.', '-', '/', whitespace) stream in
// on the slave side, one request per cycle while tready is high; tuser set means
// end of text, which closes the pending token without a byte. Each closed token
// that is a lone slash or a known dot/dash pattern (up to seven symbols) yields
// one ASCII character on the master side, anything else yields nothing. The
// character of a closing request is registered into the output register or skid;
// a two-entry output buffer (output register plus skid) keeps the input side
// open while a result waits, so tready drops only when both entries are full.
module morse_text_decoder_core
    import mtd_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    input  wire [7:0] i_s_axis_tdata,   // [7:0] text_byte
    input  wire       i_s_axis_tuser,   // [0] end_of_text
    output logic      o_m_axis_tvalid,
    input  wire       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata   // [7:0] decoded_char
);

    t_tok_in tok_in;
    t_res    res;
    logic    in_acc;
    logic    push;

    logic  r_out_valid,  n_out_valid;
    t_char r_out_data,   n_out_data;
    logic  r_skid_valid, n_skid_valid;
    t_char r_skid_data,  n_skid_data;

    assign o_s_axis_tready = !r_skid_valid;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign tok_in.req  = in_acc;
    assign tok_in.eot  = i_s_axis_tuser;
    assign tok_in.text = i_s_axis_tdata;

    mtd_token u_token (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tok_in),
        .o_res   (res)
    );

    assign push = res.valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (push) begin
            // skid is empty whenever a request is taken
            if (!r_out_valid || i_m_axis_tready) begin
                n_out_valid = 1'b1;
                n_out_data  = res.data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = res.data;
            end
        end else if (r_out_valid && i_m_axis_tready) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(in_acc))
        else $error("result appeared without an accepted request");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_out_valid && !i_m_axis_tready) |=> r_skid_valid)
        else $error("result under stall not parked in skid");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
module testbench;
    import mtd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 4;
    localparam int N_CODES     = 54;

    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_LF    = 8'h0A;
    localparam t_char CH_VT    = 8'h0B;
    localparam t_char CH_FF    = 8'h0C;
    localparam t_char CH_CR    = 8'h0D;

    // codes in the same order as the characters below
    string morse_codes [N_CODES] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        ".-.-.-", "--..--", "..--..", ".----.", "-.-.--", "-..-.", "-.--.",
        "-.--.-", ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-",
        "..--.-", ".-..-.", "...-..-", ".--.-."
    };
    string morse_letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"$@";

    logic       i_clk   = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       s_user  = 1'b0;
    logic       m_ready = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [7:0] m_data;

    // token being collected by the predictor
    t_sym cur_bits  = '0;
    int   cur_count = 0;
    bit   cur_open  = 1'b0;
    bit   cur_bad   = 1'b0;
    bit   cur_slash = 1'b0;

    t_char expected_chars [$];
    int    s_idle_pct  = 0;
    int    m_idle_pct  = 0;
    int    req_count   = 0;
    int    char_count  = 0;
    int    error_count = 0;
    int    cycle_count = 0;

    morse_text_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [7:0] text_byte
        .i_s_axis_tuser  (s_user),    // [0] end_of_text
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)     // [7:0] decoded_char
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t with %0d characters outstanding", $time,
                     expected_chars.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit lookup_morse(input int cnt, input t_sym bits, output t_char ch);
        int n;
        bit hit;
        ch = '0;
        for (int k = 0; k < N_CODES; k++) begin
            n = morse_codes[k].len();
            if (n == cnt && n > 0) begin
                hit = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (bits[n-1-i] != (t_char'(morse_codes[k][i]) == CH_DASH))
                        hit = 1'b0;
                end
                if (hit) begin
                    ch = t_char'(morse_letters[k]);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic bit is_blank(input t_char b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic t_char pick_blank();
        t_char blanks [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
        return blanks[$urandom_range(5)];
    endfunction

    // advances the token tracker by one request, queues the char a closing token yields
    function automatic void track_morse_byte(input t_char b, input bit eot);
        t_char ch;
        if (eot || is_blank(b)) begin
            if (cur_open && !cur_bad) begin
                if (cur_slash)
                    expected_chars = {expected_chars, CH_SPACE};
                else if (lookup_morse(cur_count, cur_bits, ch))
                    expected_chars = {expected_chars, ch};
            end
            cur_bits  = '0;
            cur_count = 0;
            cur_open  = 1'b0;
            cur_bad   = 1'b0;
            cur_slash = 1'b0;
        end else begin
            cur_open = 1'b1;
            if (b == CH_DOT || b == CH_DASH) begin
                if (cur_slash || cur_count >= MAX_SYMBOLS) begin
                    cur_bad = 1'b1;
                end else if (!cur_bad) begin
                    cur_bits  = {cur_bits[SYM_W-2:0], b == CH_DASH};
                    cur_count = cur_count + 1;
                end
            end else if (b == CH_SLASH) begin
                if (cur_count == 0 && !cur_slash && !cur_bad)
                    cur_slash = 1'b1;
                else
                    cur_bad = 1'b1;
            end else begin
                cur_bad = 1'b1;
            end
        end
    endfunction

    task automatic send_req(input t_char b, input bit eot);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= eot;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        track_morse_byte(b, eot);
        req_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_req(t_char'(s[i]), 1'b0);
    endtask

    // result side: random stall and in-order compare
    always @(posedge i_clk) begin
        if (rst_n && m_valid && m_ready) begin
            char_count <= char_count + 1;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected char, expected none got %h", $time, m_data);
                error_count++;
            end else begin
                if (m_data !== expected_chars[0]) begin
                    $display("%0t: decoded char mismatch, expected %h got %h", $time,
                             expected_chars[0], m_data);
                    error_count++;
                end
                void'(expected_chars.pop_front());
            end
        end
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    task automatic test_extremes();
        send_text("/");
        send_req(CH_SPACE, 1'b0);
        // flush carries a byte that must be ignored
        send_text("-----");
        send_req(8'hFF, 1'b1);
        send_text("...-..-");
        send_req(CH_TAB, 1'b0);
        send_text("-------.");
        send_req(CH_LF, 1'b0);
    endtask

    task automatic test_invalid_tokens();
        send_req(8'h00, 1'b0);
        send_req(CH_VT, 1'b0);
        send_text("-");
        send_req(8'hFF, 1'b0);
        send_req(CH_FF, 1'b0);
        send_text("//");
        send_req(CH_CR, 1'b0);
        send_text("./");
        send_req(CH_SPACE, 1'b0);
        send_text("/-");
        send_req(CH_SPACE, 1'b0);
        send_text("..--");
        send_req(8'h00, 1'b1);
        // nothing open: blanks and a flush do nothing
        send_req(CH_SPACE, 1'b0);
        send_req(CH_CR, 1'b0);
        send_req(CH_DOT, 1'b1);
    endtask

    task automatic test_random_text(input int s_pct, input int m_pct, input int n_items);
        t_char tok [$];
        int    k;
        int    start;
        int    j;
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
        start      = req_count;
        while (req_count - start < n_items) begin
            tok.delete();
            k = $urandom_range(N_CODES - 1);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    for (int i = 0; i < morse_codes[k].len(); i++)
                        tok = {tok, t_char'(morse_codes[k][i])};
                end
                5: tok = {tok, CH_SLASH};
                6: begin
                    repeat ($urandom_range(8, 1))
                        tok = {tok, ($urandom_range(1) ? CH_DASH : CH_DOT)};
                end
                7: begin
                    // one symbol swapped for an arbitrary byte
                    for (int i = 0; i < morse_codes[k].len(); i++)
                        tok = {tok, t_char'(morse_codes[k][i])};
                    j = $urandom_range(tok.size() - 1);
                    tok[j] = t_char'($urandom_range(255));
                end
                8: begin
                    if ($urandom_range(1)) tok = {tok, CH_SLASH};
                    for (int i = 0; i < morse_codes[k].len(); i++)
                        tok = {tok, t_char'(morse_codes[k][i])};
                    if (tok[0] != CH_SLASH) tok = {tok, CH_SLASH};
                end
                default: begin
                    repeat ($urandom_range(4, 1)) tok = {tok, t_char'($urandom_range(255))};
                end
            endcase
            foreach (tok[i]) send_req(tok[i], 1'b0);
            if ($urandom_range(3) == 0)
                send_req(t_char'($urandom_range(255)), 1'b1);
            else
                send_req(pick_blank(), 1'b0);
            if ($urandom_range(9) == 0) send_req(pick_blank(), 1'b0);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        s_idle_pct = 12;
        m_idle_pct = 73;
        test_extremes();
        test_invalid_tokens();
        test_random_text(12, 73, 500);
        test_random_text(73, 12, 500);
        test_random_text(0, 0, 500);
        s_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            $display("%0t: %0d chars never arrived", $time, expected_chars.size());
            error_count++;
        end

        $display("sent %0d text requests, checked %0d decoded chars", req_count, char_count);
        $display("stall mixes: sender-light, receiver-light, and none");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mtd_pkg.sv
hw/rtl/mtd_token.sv
hw/rtl/morse_text_decoder_core.sv
test/testbench.sv
